FILE: sv/sfcd_pkg.sv
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared constants, types and the CRC-8 byte step for the frame deframer.
// ----------------------------------------------------------------------------
package sfcd_pkg;

  // frame layout: six words of two data bytes and one check byte
  localparam int unsigned FrameWords = 6;
  localparam int unsigned WordBytes  = 3;

  localparam logic [2:0] LastWord  = 3'(FrameWords - 1);
  localparam logic [1:0] CheckSlot = 2'(WordBytes - 1);

  // crc-8, msb first, no final xor
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // first failing word code when every check byte matched
  localparam logic [2:0] NoFailure = 3'(FrameWords);

  // one finished frame
  typedef struct packed {
    logic [31:0] co2_bits;
    logic [31:0] temperature_bits;
    logic [31:0] humidity_bits;
    logic        crc_ok;
    logic [2:0]  first_bad_word;
  } result_t;

  // one byte through the crc, eight shift steps unrolled
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/sfcd_frame_core.sv
// ----------------------------------------------------------------------------
// sfcd_frame_core
// Frame state: byte position, running crc, value assembly and first failure.
// ----------------------------------------------------------------------------
module sfcd_frame_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              frame_start_i,
  output logic              last_o,
  output logic              res_valid_o,
  output sfcd_pkg::result_t res_o
);
  import sfcd_pkg::*;

  logic [2:0]  word_q, word_d;
  logic [1:0]  slot_q, slot_d;
  logic [7:0]  crc_q, crc_d;
  logic [31:0] co2_q, co2_d;
  logic [31:0] temp_q, temp_d;
  logic [31:0] hum_q, hum_d;
  logic [2:0]  fail_q, fail_d;

  logic        restart;
  logic [2:0]  word_e;
  logic [1:0]  slot_e;
  logic [7:0]  crc_e;
  logic [31:0] co2_e, temp_e, hum_e;
  logic [2:0]  fail_e;
  logic [31:0] co2_n, temp_n, hum_n;
  logic [2:0]  fail_n;
  logic        last;

  // effective state after an optional restart
  assign restart = frame_start_i || (word_q > LastWord) || (slot_q > CheckSlot);
  assign word_e  = restart ? '0 : word_q;
  assign slot_e  = restart ? '0 : slot_q;
  assign crc_e   = restart ? CrcInit : crc_q;
  assign co2_e   = restart ? '0 : co2_q;
  assign temp_e  = restart ? '0 : temp_q;
  assign hum_e   = restart ? '0 : hum_q;
  assign fail_e  = restart ? NoFailure : fail_q;
  assign last    = (word_e == LastWord) && (slot_e == CheckSlot);

  // per-byte update of crc, values and failure index
  always_comb begin
    crc_d  = crc_e;
    co2_n  = co2_e;
    temp_n = temp_e;
    hum_n  = hum_e;
    fail_n = fail_e;
    if (slot_e != CheckSlot) begin
      crc_d = crc8_byte(crc_e, rx_byte_i);
      if (word_e < 3'd2) begin
        co2_n = {co2_e[23:0], rx_byte_i};
      end else if (word_e < 3'd4) begin
        temp_n = {temp_e[23:0], rx_byte_i};
      end else begin
        hum_n = {hum_e[23:0], rx_byte_i};
      end
    end else begin
      if ((crc_e != rx_byte_i) && (fail_e == NoFailure)) begin
        fail_n = word_e;
      end
      crc_d = CrcInit;
    end
  end

  // position advance and clear after the last byte
  always_comb begin
    if (last) begin
      word_d = '0;
      slot_d = '0;
      co2_d  = '0;
      temp_d = '0;
      hum_d  = '0;
      fail_d = NoFailure;
    end else begin
      word_d = (slot_e == CheckSlot) ? word_e + 3'd1 : word_e;
      slot_d = (slot_e == CheckSlot) ? '0 : slot_e + 2'd1;
      co2_d  = co2_n;
      temp_d = temp_n;
      hum_d  = hum_n;
      fail_d = fail_n;
    end
  end

  // result of the frame, valid with the last byte
  assign last_o                  = last;
  assign res_valid_o             = en_i && last;
  assign res_o.co2_bits          = co2_n;
  assign res_o.temperature_bits  = temp_n;
  assign res_o.humidity_bits     = hum_n;
  assign res_o.crc_ok            = (fail_n == NoFailure);
  assign res_o.first_bad_word    = fail_n;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      slot_q <= '0;
      crc_q  <= CrcInit;
      co2_q  <= '0;
      temp_q <= '0;
      hum_q  <= '0;
      fail_q <= NoFailure;
    end else if (en_i) begin
      word_q <= word_d;
      slot_q <= slot_d;
      crc_q  <= crc_d;
      co2_q  <= co2_d;
      temp_q <= temp_d;
      hum_q  <= hum_d;
      fail_q <= fail_d;
    end
  end

endmodule

FILE: sv/sfcd_out_reg.sv
// ----------------------------------------------------------------------------
// sfcd_out_reg
// Result register with valid/ready toward the receiver.
// ----------------------------------------------------------------------------
module sfcd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sfcd_pkg::result_t res_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sfcd_pkg::result_t res_o
);
  import sfcd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // free when empty or when the held transaction leaves this cycle
  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: sv/sensor_frame_crc_deframer.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_deframer
// Deframes an 18-byte measurement response with per-word crc-8 checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one response byte per
//   transaction, with frame_start_i marking byte 0 of a frame; without it the
//   block wraps to byte 0 by itself after the 18th byte.
//   Output channel (out_valid_o/out_ready_i) carries one transaction per
//   frame: three 32-bit float patterns, crc_ok_o and first_bad_word_o
//   (6 when every word passed). A failed frame is still delivered.
//   Throughput: one byte per cycle unless a final byte waits for a busy
//   result register. Bytes land in an input register, the frame logic (one
//   unrolled crc-8 step and the value shifters) updates its state as the
//   byte moves on, and the frame result lands in the output register; a
//   closing byte thus passes both registers before out_valid_o rises.
//   Reset clears the valid flags of the input and output registers and
//   returns the frame state to byte 0 with an empty crc.
//   While the receiver stalls a pending result, non-final bytes keep
//   flowing; the final byte of the next frame waits in the input register
//   and in_ready_o drops until the result is taken.
// ----------------------------------------------------------------------------
module sensor_frame_crc_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] co2_bits_o,
  output logic [31:0] temperature_bits_o,
  output logic [31:0] humidity_bits_o,
  output logic        crc_ok_o,
  output logic [2:0]  first_bad_word_o
);
  import sfcd_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       start_q;
  logic       advance;
  logic       core_last;
  logic       core_res_valid;
  logic       out_free;
  logic       out_free_or_none;
  result_t    core_res;
  result_t    out_res;

  // frame logic works on the byte held in the input register
  sfcd_frame_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .rx_byte_i     (byte_q),
    .frame_start_i (start_q),
    .last_o        (core_last),
    .res_valid_o   (core_res_valid),
    .res_o         (core_res)
  );

  // a held byte moves on unless it closes a frame and the result slot is busy
  assign out_free_or_none = out_free || !core_last;
  assign advance          = in_valid_q && out_free_or_none;
  assign in_ready_o       = !in_valid_q || advance;
  assign in_valid_d       = in_ready_o ? in_valid_i : in_valid_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= rx_byte_i;
      start_q <= frame_start_i;
    end
  end

  // result register
  sfcd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (core_res_valid),
    .res_i       (core_res),
    .ready_o     (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign co2_bits_o         = out_res.co2_bits;
  assign temperature_bits_o = out_res.temperature_bits;
  assign humidity_bits_o    = out_res.humidity_bits;
  assign crc_ok_o           = out_res.crc_ok;
  assign first_bad_word_o   = out_res.first_bad_word;

endmodule

FILE: sv/sfcd_checker.sv
// ----------------------------------------------------------------------------
// sfcd_checker
// Port-level checks for the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  rx_byte_i,
  input logic        frame_start_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] co2_bits_o,
  input logic [31:0] temperature_bits_o,
  input logic [31:0] humidity_bits_o,
  input logic        crc_ok_o,
  input logic [2:0]  first_bad_word_o
);
  import sfcd_pkg::*;

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(co2_bits_o) &&
      $stable(temperature_bits_o) && $stable(humidity_bits_o) &&
      $stable(crc_ok_o) && $stable(first_bad_word_o))
    else $error("result changed while stalled");

  // pass flag agrees with the failure index
  a_crc_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> crc_ok_o == (first_bad_word_o == NoFailure))
    else $error("crc_ok disagrees with first_bad_word");

  // failure index names a real word or none
  a_bad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> first_bad_word_o <= NoFailure)
    else $error("first_bad_word out of range");

  // no result while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind sensor_frame_crc_deframer sfcd_checker u_sfcd_checker (.*);

FILE: tb/sfcd_frame_checker.sv
// ----------------------------------------------------------------------------
// sfcd_frame_checker
// Watches both channels of the deframer, predicts each finished frame from
// the accepted bytes and compares every delivered result field by field.
// ----------------------------------------------------------------------------
module sfcd_frame_checker
  import sfcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] co2_bits_i,
  input  logic [31:0] temperature_bits_i,
  input  logic [31:0] humidity_bits_i,
  input  logic        crc_ok_i,
  input  logic [2:0]  first_bad_word_i,
  output int          fail_count_o,
  output int          frames_pending_o
);

  localparam int unsigned FrameBytes = FrameWords * WordBytes;

  // predicted deframer state
  logic [4:0]  next_pos;
  logic [7:0]  word_crc;
  logic [31:0] co2_acc;
  logic [31:0] temp_acc;
  logic [31:0] hum_acc;
  logic [2:0]  lowest_bad;

  result_t expected_frames[$];
  int      mismatches;

  assign fail_count_o     = mismatches;
  assign frames_pending_o = expected_frames.size();

  // crc-8 fed one data bit at a time, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return r;
  endfunction

  task automatic restart_frame();
    next_pos   = '0;
    word_crc   = CrcInit;
    co2_acc    = '0;
    temp_acc   = '0;
    hum_acc    = '0;
    lowest_bad = NoFailure;
  endtask

  // advance the prediction by one accepted byte, queue a frame when complete
  task automatic deframe_byte(input logic [7:0] b, input logic start);
    logic [4:0] at;
    logic [2:0] word;
    logic [1:0] slot;
    result_t    done;
    if (start || next_pos >= FrameBytes) begin
      restart_frame();
    end
    at   = next_pos;
    word = 3'(at / WordBytes);
    slot = 2'(at % WordBytes);
    if (slot != CheckSlot) begin
      word_crc = crc8_step(word_crc, b);
      if (word < 3'd2) begin
        co2_acc = {co2_acc[23:0], b};
      end else if (word < 3'd4) begin
        temp_acc = {temp_acc[23:0], b};
      end else begin
        hum_acc = {hum_acc[23:0], b};
      end
    end else begin
      if (word_crc != b && lowest_bad == NoFailure) begin
        lowest_bad = word;
      end
      word_crc = CrcInit;
    end
    if (at != 5'(FrameBytes - 1)) begin
      next_pos = at + 5'd1;
    end else begin
      done.co2_bits         = co2_acc;
      done.temperature_bits = temp_acc;
      done.humidity_bits    = hum_acc;
      done.crc_ok           = (lowest_bad == NoFailure);
      done.first_bad_word   = lowest_bad;
      expected_frames.push_back(done);
      restart_frame();
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // sample both channels on each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_frame();
      expected_frames.delete();
      mismatches = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        deframe_byte(rx_byte_i, frame_start_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h %h %h %b %0d", $time,
                   co2_bits_i, temperature_bits_i, humidity_bits_i, crc_ok_i,
                   first_bad_word_i);
          mismatches++;
        end else begin
          check_field("co2_bits", expected_frames[0].co2_bits, co2_bits_i);
          check_field("temperature_bits", expected_frames[0].temperature_bits,
                      temperature_bits_i);
          check_field("humidity_bits", expected_frames[0].humidity_bits, humidity_bits_i);
          check_field("crc_ok", 32'(expected_frames[0].crc_ok), 32'(crc_ok_i));
          check_field("first_bad_word", 32'(expected_frames[0].first_bad_word),
                      32'(first_bad_word_i));
          void'(expected_frames.pop_front());
        end
      end
    end
  end

endmodule

FILE: tb/sensor_frame_crc_deframer_test.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_deframer_test
// Drives response bytes into the deframer: a directed aborted frame and a
// frame with extreme data and two bad check bytes, then random frames with
// mostly correct check bytes, some truncated, with random idling on both
// channels. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module sensor_frame_crc_deframer_test;
  import sfcd_pkg::*;

  localparam int unsigned FrameBytes = FrameWords * WordBytes;
  localparam int          StallLimit = 2000;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i     = '0;
  logic        frame_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [31:0] co2_bits_o;
  logic [31:0] temperature_bits_o;
  logic [31:0] humidity_bits_o;
  logic        crc_ok_o;
  logic [2:0]  first_bad_word_o;

  int fail_count;
  int frames_pending;
  int bytes_sent = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  sensor_frame_crc_deframer dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .rx_byte_i,
    .frame_start_i,
    .out_valid_o,
    .out_ready_i,
    .co2_bits_o,
    .temperature_bits_o,
    .humidity_bits_o,
    .crc_ok_o,
    .first_bad_word_o
  );

  sfcd_frame_checker checker_i (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i         (in_ready_o),
    .rx_byte_i,
    .frame_start_i,
    .out_valid_i        (out_valid_o),
    .out_ready_i,
    .co2_bits_i         (co2_bits_o),
    .temperature_bits_i (temperature_bits_o),
    .humidity_bits_i    (humidity_bits_o),
    .crc_ok_i           (crc_ok_o),
    .first_bad_word_i   (first_bad_word_o),
    .fail_count_o       (fail_count),
    .frames_pending_o   (frames_pending)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // receiver stalls, none while steady
  always @(posedge clk_i) begin
    out_ready_i <= steady ? 1'b1 : ($urandom_range(99) >= 9);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one byte transaction, with an optional gap in front
  task automatic send_byte(input logic [7:0] b, input logic start);
    bit took;
    while (!steady && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rx_byte_i     <= b;
    frame_start_i <= start;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    bytes_sent++;
  endtask

  // hold the sender until every predicted frame has been delivered
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (frames_pending != 0);
    @(posedge clk_i);
  endtask

  // random frame of len bytes, check bytes mostly correct
  task automatic send_frame(input logic lead_start, input int unsigned len);
    logic [7:0] crc;
    logic [7:0] b;
    crc = CrcInit;
    for (int unsigned i = 0; i < len; i++) begin
      if (i % WordBytes != CheckSlot) begin
        b   = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
        crc = crc8_byte(crc, b);
      end else begin
        b   = ($urandom_range(99) < 12) ? (crc ^ 8'($urandom_range(1, 255))) : crc;
        crc = CrcInit;
      end
      send_byte(b, lead_start && i == 0);
    end
  endtask

  // stimulus
  initial begin
    logic [15:0] edge_data [FrameWords];
    logic [7:0]  crc;
    int unsigned len;
    int          frame_no;
    bit          resync;
    edge_data = '{16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE, 16'h00FF, 16'hFF00};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // aborted frame, dropped by the next frame start
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);

    // extreme data, bad check bytes in words 1 and 4
    for (int w = 0; w < FrameWords; w++) begin
      crc = crc8_byte(crc8_byte(CrcInit, edge_data[w][15:8]), edge_data[w][7:0]);
      send_byte(edge_data[w][15:8], w == 0);
      send_byte(edge_data[w][7:0], 1'b0);
      send_byte((w == 1 || w == 4) ? ~crc : crc, 1'b0);
    end
    wait_all_results();

    // random frames, the first one wrapping without a frame start
    frame_no = 0;
    resync   = 1'b0;
    while (bytes_sent < 722) begin
      steady <= (frame_no >= 8 && frame_no < 18);
      if (frame_no == 22) begin
        wait_all_results();
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(1, FrameBytes - 1) : FrameBytes;
      send_frame(frame_no != 0 && (resync || $urandom_range(1)), len);
      resync = (len != FrameBytes);
      frame_no++;
    end
    wait_all_results();
    steady <= 1'b0;
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/sfcd_pkg.sv
sv/sfcd_frame_core.sv
sv/sfcd_out_reg.sv
sv/sensor_frame_crc_deframer.sv
sv/sfcd_checker.sv
tb/sfcd_frame_checker.sv
tb/sensor_frame_crc_deframer_test.sv
